[rtl/gdfs_pkg.sv]
//------------------------------------------------------------------------------
// gdfs_pkg
// Shared constants for the depth-first graph walk core.
//------------------------------------------------------------------------------
`default_nettype none

package gdfs_pkg;

   localparam int unsigned MaxVertices    = 64;
   localparam int unsigned MaxListEntries = 256;

   // Input kinds.
   localparam logic KIND_ADD_EDGE   = 1'b0;
   localparam logic KIND_START_WALK = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_OUT_RANGE = 2'd2;

   localparam int unsigned VertexCountWidth = 7;
   localparam logic [VertexCountWidth-1:0] VertexCountReset = 7'd64;

endpackage

`default_nettype wire

[rtl/graph_dfs_stack_traversal_core.sv]
//------------------------------------------------------------------------------
// graph_dfs_stack_traversal_core
// Undirected graph store with an iterative depth-first walk.
//------------------------------------------------------------------------------
// Requests enter on req_ (tuser = kind, tdata = first and second vertex).
// An add-edge request returns one status on rsp_ and, when the status is ok,
// appends each endpoint to the other's neighbor list. A start request with an
// in-range vertex returns every visited vertex, in visit order, and marks the
// final one with rsp_tlast. Adjacency lists, list heads and tails and the walk
// stack live in synchronous memories with registered read data.
// An edge status is loaded into the output register when the request is
// accepted; the two list appends follow in ST_EDGE_A and ST_EDGE_B, and no
// new request is taken before both are done.
// A walk step reads the stack top, then the list head and tail, then the first
// entry, and then checks list entries one by one; a vertex with an empty list
// is popped after its stack read. A visit is held back until the next visit is
// found or the stack runs empty, so each result leaves one step late; a visit
// waits in ST_OUT until the output register is free.
// Only one request is in work at a time; req_tready is low while busy or
// while a result waits in the output register. The sequencer waits while the
// receiver stalls, so no result is lost.
// Reset clears the visited marks, list valid bits, entry count and stack
// depth at once; no clearing pass is needed. csr_ writes vertex_count.
//------------------------------------------------------------------------------
`default_nettype none

module graph_dfs_stack_traversal_core #(
   parameter int unsigned MAX_VERTICES     = gdfs_pkg::MaxVertices,
   parameter int unsigned MAX_LIST_ENTRIES = gdfs_pkg::MaxListEntries
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration write: vertex_count.
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [6:0]  csr_data,
   // Requests.
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,  // [5:0] first_vertex, [11:6] second_vertex
   input  wire logic        req_tuser,  // [0] kind
   // Results.
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,  // [1:0] status, [7:2] visited_vertex
   output      logic        rsp_tlast
);

   localparam int unsigned VW = 6;
   localparam int unsigned EW = $clog2(MAX_LIST_ENTRIES);
   localparam int unsigned SW = $clog2(MAX_VERTICES);
   localparam int unsigned NW = EW + 1;
   localparam int unsigned DW = SW + 1;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_EDGE_A = 4'd1;
   localparam logic [3:0] ST_EDGE_B = 4'd2;
   localparam logic [3:0] ST_TOP    = 4'd3;
   localparam logic [3:0] ST_TOPRD  = 4'd4;
   localparam logic [3:0] ST_ENTRD  = 4'd5;
   localparam logic [3:0] ST_ENTCHK = 4'd6;
   localparam logic [3:0] ST_OUT    = 4'd7;
   localparam logic [3:0] ST_HTRD   = 4'd8;

   // Memories.
   logic [VW-1:0] tgt_mem  [MAX_LIST_ENTRIES];
   logic [EW-1:0] link_mem [MAX_LIST_ENTRIES];
   logic [VW-1:0] stk_mem  [MAX_VERTICES];
   logic [EW-1:0] head_mem [MAX_VERTICES];
   logic [EW-1:0] tail_mem [MAX_VERTICES];
   logic [VW-1:0] tgt_rd;
   logic [EW-1:0] link_rd;
   logic [VW-1:0] stk_rd;
   logic [EW-1:0] head_rd;
   logic [EW-1:0] tail_rd;

   // Per-vertex flop state.
   logic [MAX_VERTICES-1:0] vis_ff, vis_in;
   logic [MAX_VERTICES-1:0] lval_ff, lval_in;

   logic [3:0]    state_ff, state_in;
   logic [6:0]    vcount_ff;
   logic [NW-1:0] used_ff, used_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [VW-1:0] a_ff, a_in, b_ff, b_in;
   logic [VW-1:0] cur_ff, cur_in;
   logic [VW-1:0] pend_ff, pend_in;
   logic [EW-1:0] ent_ff, ent_in;
   logic [EW-1:0] ctail_ff, ctail_in;
   logic [6:0]    nres_ff, nres_in;
   logic          ovld_ff, ovld_in;
   logic [1:0]    ost_ff, ost_in;
   logic [VW-1:0] overt_ff, overt_in;
   logic          olast_ff, olast_in;

   // Memory port controls.
   logic          ent_we, ent_link_we;
   logic [EW-1:0] ent_waddr, ent_link_waddr, ent_raddr;
   logic [VW-1:0] ent_wtgt;
   logic          stk_we;
   logic [SW-1:0] stk_waddr, stk_raddr;
   logic [VW-1:0] stk_wdata;
   logic          head_we, tail_we;
   logic [VW-1:0] ht_vert;
   logic [EW-1:0] ht_val;
   logic [VW-1:0] ht_raddr;

   logic [6:0]    lim;
   logic [VW-1:0] req_a, req_b;

   assign lim   = (vcount_ff > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount_ff;
   assign req_a = req_tdata[5:0];
   assign req_b = req_tdata[11:6];

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && !ovld_ff;
   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = {overt_ff, ost_ff};
   assign rsp_tlast  = olast_ff;

   // Entry memories: targets are written for new entries, links when an
   // entry is appended behind an existing tail. The link of a tail entry is
   // never followed, so a new entry needs no link write.
   always_ff @(posedge clock) begin
      if (ent_we) begin
         tgt_mem[ent_waddr] <= ent_wtgt;
      end
      if (ent_link_we) begin
         link_mem[ent_link_waddr] <= ent_waddr;
      end
      tgt_rd  <= tgt_mem[ent_raddr];
      link_rd <= link_mem[ent_raddr];
   end

   // Walk stack memory.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd <= stk_mem[stk_raddr];
   end

   // List head and tail memories.
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[ht_vert[SW-1:0]] <= ht_val;
      end
      if (tail_we) begin
         tail_mem[ht_vert[SW-1:0]] <= ht_val;
      end
      head_rd <= head_mem[ht_raddr[SW-1:0]];
      tail_rd <= tail_mem[ht_raddr[SW-1:0]];
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      vis_in   = vis_ff;
      lval_in  = lval_ff;
      used_in  = used_ff;
      depth_in = depth_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      cur_in   = cur_ff;
      pend_in  = pend_ff;
      ent_in   = ent_ff;
      ctail_in = ctail_ff;
      nres_in  = nres_ff;
      ovld_in  = ovld_ff && !rsp_tready;
      ost_in   = ost_ff;
      overt_in = overt_ff;
      olast_in = olast_ff;
      ent_we = 1'b0; ent_link_we = 1'b0;
      ent_waddr = used_ff[EW-1:0]; ent_link_waddr = '0; ent_wtgt = '0;
      ent_raddr = ent_ff;
      stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0;
      stk_raddr = SW'(depth_ff - DW'(1));
      head_we = 1'b0; tail_we = 1'b0; ht_vert = '0; ht_val = used_ff[EW-1:0];
      ht_raddr = b_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // Read the first endpoint's tail in case an edge is accepted.
            ht_raddr = req_a;
            if (req_tvalid && req_tready) begin
               a_in = req_a;
               b_in = req_b;
               if (req_tuser == gdfs_pkg::KIND_ADD_EDGE) begin
                  ovld_in  = 1'b1;
                  olast_in = 1'b1;
                  overt_in = '0;
                  if ({1'b0, req_a} >= lim || {1'b0, req_b} >= lim) begin
                     ost_in = gdfs_pkg::STATUS_OUT_RANGE;
                  end else if (32'(used_ff) + 2 > MAX_LIST_ENTRIES) begin
                     ost_in = gdfs_pkg::STATUS_FULL;
                  end else begin
                     ost_in = gdfs_pkg::STATUS_OK;
                     state_in = ST_EDGE_A;
                  end
               end else if ({1'b0, req_a} >= lim) begin
                  ovld_in  = 1'b1;
                  olast_in = 1'b1;
                  overt_in = '0;
                  ost_in   = gdfs_pkg::STATUS_OUT_RANGE;
               end else begin
                  // Visit the start vertex and push it. The visit waits in
                  // pend_ff until the next visit or the end of the walk.
                  pend_in = req_a;
                  vis_in[req_a[SW-1:0]] = 1'b1;
                  stk_we = 1'b1; stk_waddr = '0; stk_wdata = req_a;
                  depth_in = DW'(1);
                  nres_in  = 7'd1;
                  state_in = ST_TOP;
               end
            end
         end
         ST_EDGE_A, ST_EDGE_B: begin
            // Append an entry to one endpoint's list.
            ht_vert  = (state_ff == ST_EDGE_A) ? a_ff : b_ff;
            ent_wtgt = (state_ff == ST_EDGE_A) ? b_ff : a_ff;
            ent_we   = 1'b1;
            if (lval_ff[ht_vert[SW-1:0]]) begin
               ent_link_we = 1'b1;
               // For a self loop the tail read for the second endpoint is
               // stale; the entry just written is the true tail.
               if (state_ff == ST_EDGE_B && a_ff == b_ff) begin
                  ent_link_waddr = used_ff[EW-1:0] - EW'(1);
               end else begin
                  ent_link_waddr = tail_rd;
               end
            end else begin
               head_we = 1'b1;
               lval_in[ht_vert[SW-1:0]] = 1'b1;
            end
            tail_we = 1'b1;
            used_in = used_ff + NW'(1);
            state_in = (state_ff == ST_EDGE_A) ? ST_EDGE_B : ST_IDLE;
         end
         ST_TOP: begin
            // Stack read issued by default address. An empty stack ends the
            // walk: the held visit goes out as the final result.
            if (depth_ff == '0) begin
               if (!ovld_ff || rsp_tready) begin
                  ovld_in  = 1'b1;
                  ost_in   = gdfs_pkg::STATUS_OK;
                  overt_in = pend_ff;
                  olast_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_TOPRD;
            end
         end
         ST_TOPRD: begin
            if (!lval_ff[stk_rd[SW-1:0]]) begin
               depth_in = depth_ff - DW'(1);
               state_in = ST_TOP;
            end else begin
               ht_raddr = stk_rd;
               state_in = ST_HTRD;
            end
         end
         ST_HTRD: begin
            ent_in   = head_rd;
            ctail_in = tail_rd;
            state_in = ST_ENTRD;
         end
         ST_ENTRD: begin
            state_in = ST_ENTCHK;
         end
         ST_ENTCHK: begin
            if (!vis_ff[tgt_rd[SW-1:0]] && depth_ff < DW'(MAX_VERTICES)
                && nres_ff < 7'd64) begin
               vis_in[tgt_rd[SW-1:0]] = 1'b1;
               stk_we = 1'b1; stk_waddr = depth_ff[SW-1:0]; stk_wdata = tgt_rd;
               depth_in = depth_ff + DW'(1);
               nres_in  = nres_ff + 7'd1;
               cur_in   = tgt_rd;
               state_in = ST_OUT;
            end else if (!vis_ff[tgt_rd[SW-1:0]] || ent_ff == ctail_ff) begin
               depth_in = depth_ff - DW'(1);
               state_in = ST_TOP;
            end else begin
               ent_in = link_rd;
               state_in = ST_ENTRD;
            end
         end
         ST_OUT: begin
            // A new visit was found, so the held one is not the last: send it
            // once the output register is free and hold the new one.
            if (!ovld_ff || rsp_tready) begin
               ovld_in  = 1'b1;
               ost_in   = gdfs_pkg::STATUS_OK;
               overt_in = pend_ff;
               olast_in = 1'b0;
               pend_in  = cur_ff;
               state_in = ST_TOP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         vis_ff    <= '0;
         lval_ff   <= '0;
         used_ff   <= '0;
         depth_ff  <= '0;
         vcount_ff <= gdfs_pkg::VertexCountReset;
         ovld_ff   <= 1'b0;
         olast_ff  <= 1'b0;
         nres_ff   <= '0;
      end else begin
         state_ff <= state_in;
         vis_ff   <= vis_in;
         lval_ff  <= lval_in;
         used_ff  <= used_in;
         depth_ff <= depth_in;
         ovld_ff  <= ovld_in;
         olast_ff <= olast_in;
         nres_ff  <= nres_in;
         if (csr_valid && csr_ready) begin
            vcount_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      cur_ff   <= cur_in;
      pend_ff  <= pend_in;
      ent_ff   <= ent_in;
      ctail_ff <= ctail_in;
      ost_ff   <= ost_in;
      overt_ff <= overt_in;
   end

endmodule

`default_nettype wire

[rtl/gdfs_checker.sv]
//------------------------------------------------------------------------------
// gdfs_checker
// Port-level checks for the depth-first graph walk core.
//------------------------------------------------------------------------------
`default_nettype none

module gdfs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Status is never above the out-of-range code.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] <= gdfs_pkg::STATUS_OUT_RANGE)
      else $error("bad status");

   // Non-ok results are always final.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != gdfs_pkg::STATUS_OK |-> rsp_tlast)
      else $error("error result not last");

   // A request is not taken while a result waits.
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted with result pending");

endmodule

bind graph_dfs_stack_traversal_core gdfs_checker u_gdfs_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);

`default_nettype wire
